// ===== rtl/ptprx_pkg.sv =====
// ----------------------------------------------------------------------------
// ptprx_pkg
// Shared types and constants of the PTP receive timestamp filter.
// ----------------------------------------------------------------------------
package ptprx_pkg;

    localparam int SLOTS  = 4;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 8;

    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_PTP      = 16'h88F7;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] PORT_EVENT     = 16'h013F;
    localparam logic [15:0] PORT_GENERAL   = 16'h0140;
    localparam logic [7:0]  V1_ANY         = 8'hFF;
    localparam logic [3:0]  V2_ANY         = 4'hF;
    localparam logic [3:0]  V2_EVENT_LIMIT = 4'd8;
    localparam logic [15:0] V1_VERSION     = 16'd1;
    localparam logic [3:0]  V2_VERSION     = 4'd2;

    typedef enum logic [CFG_IW-1:0] {
        CFG_TS_ENABLE = 3'd0,
        CFG_TS_TYPE   = 3'd1,
        CFG_UDP_PORT  = 3'd2,
        CFG_V1_TYPE_A = 3'd3,
        CFG_V1_TYPE_B = 3'd4,
        CFG_V2_TYPE_A = 3'd5,
        CFG_V2_TYPE_B = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        TS_L2_V2    = 2'd0,
        TS_V1_UDP   = 2'd1,
        TS_V2       = 2'd2,
        TS_V2_EVENT = 2'd3
    } t_ts_type;

    typedef struct packed {
        logic       ts_enable;
        t_ts_type   ts_type;
        logic [1:0] udp_port_enable;
        logic [7:0] v1_type_a;
        logic [7:0] v1_type_b;
        logic [3:0] v2_type_a;
        logic [3:0] v2_type_b;
    } t_cfg;

    typedef struct packed {
        logic [15:0] ethertype;
        logic [7:0]  ip_proto;
        logic [15:0] udp_dst_port;
        logic [15:0] v1_version;
        logic [7:0]  v1_msg_type;
        logic [3:0]  v2_version;
        logic [3:0]  v2_msg_type;
    } t_hdr;

endpackage

// ===== rtl/ptprx_filter.sv =====
// ----------------------------------------------------------------------------
// ptprx_filter
// Header match: decides whether a frame qualifies for a receive timestamp.
// ----------------------------------------------------------------------------
module ptprx_filter import ptprx_pkg::*; (
    input  t_cfg i_cfg,
    input  t_hdr i_hdr,
    output logic o_match
);

    logic is_udp;
    logic is_l2;
    logic port_ok;
    logic transport_ok;
    logic v1_ok;
    logic v2_ok;

    always_comb begin
        is_udp  = (i_hdr.ethertype == ETYPE_IPV4) && (i_hdr.ip_proto == PROTO_UDP);
        is_l2   = (i_hdr.ethertype == ETYPE_PTP);
        port_ok = ((i_hdr.udp_dst_port == PORT_EVENT) && i_cfg.udp_port_enable[0])
               || ((i_hdr.udp_dst_port == PORT_GENERAL) && i_cfg.udp_port_enable[1]);

        transport_ok = i_cfg.ts_enable
                    && ((is_udp && (i_cfg.ts_type != TS_L2_V2) && port_ok)
                     || (!is_udp && is_l2 && (i_cfg.ts_type != TS_V1_UDP)));

        v1_ok = (i_cfg.ts_type == TS_V1_UDP)
             && ((i_cfg.v1_type_a == V1_ANY) || (i_cfg.v1_type_b == V1_ANY)
              || (i_hdr.v1_msg_type == i_cfg.v1_type_a)
              || (i_hdr.v1_msg_type == i_cfg.v1_type_b));

        v2_ok = 1'b0;
        if ((i_cfg.ts_type != TS_V1_UDP) && !((i_cfg.ts_type == TS_L2_V2) && is_udp)) begin
            if (i_cfg.ts_type == TS_V2_EVENT) begin
                v2_ok = (i_hdr.v2_msg_type < V2_EVENT_LIMIT);
            end else begin
                v2_ok = (i_cfg.v2_type_a == V2_ANY)
                     || (i_hdr.v2_msg_type == i_cfg.v2_type_a)
                     || (i_hdr.v2_msg_type == i_cfg.v2_type_b);
            end
        end

        // v1 version takes precedence over the v2 nibble
        if (!transport_ok) begin
            o_match = 1'b0;
        end else if (i_hdr.v1_version == V1_VERSION) begin
            o_match = v1_ok;
        end else if (i_hdr.v2_version == V2_VERSION) begin
            o_match = v2_ok;
        end else begin
            o_match = 1'b0;
        end
    end

endmodule

// ===== rtl/ptp_rx_timestamp_filter_core.sv =====
// ----------------------------------------------------------------------------
// ptp_rx_timestamp_filter_core
// Receive timestamp filter with four lockable capture slots.
//
//   channel   direction  handshake              payload
//   in        sink       i_in_valid/o_in_ready  func, accepted, headers, clock, slot
//   out       source     o_out_valid/i_out_ready sampled, slot_valid, slot_id, stamp, mask
//   cfg       sink       i_cfg_we               i_cfg_index, i_cfg_wdata
//
// One item per cycle while the result output is not stalled.
// Items are captured in an input register and resolved against the slot
// state into the result register.
// A stalled result holds the input register; input ready drops only then.
// Synchronous reset clears config, slot locks and slot stamps.
// ----------------------------------------------------------------------------
module ptp_rx_timestamp_filter_core import ptprx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_wdata,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic              i_accepted,
    input  logic [15:0]       i_ethertype,
    input  logic [7:0]        i_ip_proto,
    input  logic [15:0]       i_udp_dst_port,
    input  logic [15:0]       i_v1_version,
    input  logic [7:0]        i_v1_msg_type,
    input  logic [3:0]        i_v2_version,
    input  logic [3:0]        i_v2_msg_type,
    input  logic [63:0]       i_clock_now,
    input  logic [1:0]        i_slot_select,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_sampled,
    output logic              o_slot_valid,
    output logic [1:0]        o_slot_id,
    output logic [63:0]       o_stamp,
    output logic [3:0]        o_locked_mask
);

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic             r_func;
    logic             r_accepted;
    t_hdr             r_hdr;
    logic [63:0]      r_clock;
    logic [1:0]       r_sel;
    logic [SLOTS-1:0] r_locked;
    logic [63:0]      r_stamp [SLOTS];
    logic             r_out_valid;
    logic             r_sampled;
    logic             r_slot_valid;
    logic [1:0]       r_slot_id;
    logic [63:0]      r_out_stamp;
    logic [3:0]       r_mask;

    logic [SLOTS-1:0] n_locked;
    logic [63:0]      n_stamp [SLOTS];
    logic             n_sampled;
    logic             n_slot_valid;
    logic [1:0]       n_slot_id;
    logic [63:0]      n_out_stamp;
    logic             w_match;
    logic             w_advance;
    logic             w_process;
    logic             w_found;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_process  = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TS_ENABLE: r_cfg.ts_enable       <= i_cfg_wdata[0];
                CFG_TS_TYPE:   r_cfg.ts_type         <= t_ts_type'(i_cfg_wdata[1:0]);
                CFG_UDP_PORT:  r_cfg.udp_port_enable <= i_cfg_wdata[1:0];
                CFG_V1_TYPE_A: r_cfg.v1_type_a       <= i_cfg_wdata;
                CFG_V1_TYPE_B: r_cfg.v1_type_b       <= i_cfg_wdata;
                CFG_V2_TYPE_A: r_cfg.v2_type_a       <= i_cfg_wdata[3:0];
                CFG_V2_TYPE_B: r_cfg.v2_type_b       <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func                 <= i_func;
            r_accepted             <= i_accepted;
            r_hdr.ethertype        <= i_ethertype;
            r_hdr.ip_proto         <= i_ip_proto;
            r_hdr.udp_dst_port     <= i_udp_dst_port;
            r_hdr.v1_version       <= i_v1_version;
            r_hdr.v1_msg_type      <= i_v1_msg_type;
            r_hdr.v2_version       <= i_v2_version;
            r_hdr.v2_msg_type      <= i_v2_msg_type;
            r_clock                <= i_clock_now;
            r_sel                  <= i_slot_select;
        end
    end

    ptprx_filter u_filter (
        .i_cfg   (r_cfg),
        .i_hdr   (r_hdr),
        .o_match (w_match)
    );

    always_comb begin
        n_locked     = r_locked;
        n_stamp      = r_stamp;
        n_sampled    = 1'b0;
        n_slot_valid = 1'b0;
        n_slot_id    = '0;
        n_out_stamp  = '0;
        w_found      = 1'b0;
        if (!r_func) begin
            if (r_accepted && w_match) begin
                n_sampled = 1'b1;
                // lowest free slot wins
                for (int i = 0; i < SLOTS; i++) begin
                    if (!w_found && !r_locked[i]) begin
                        w_found      = 1'b1;
                        n_locked[i]  = 1'b1;
                        n_stamp[i]   = r_clock;
                        n_slot_valid = 1'b1;
                        n_slot_id    = 2'(i);
                    end
                end
            end
        end else begin
            n_slot_id = r_sel;
            for (int i = 0; i < SLOTS; i++) begin
                if (32'(r_sel) == i) begin
                    n_slot_valid = r_locked[i];
                    n_out_stamp  = r_stamp[i];
                    n_locked[i]  = 1'b0;
                end
            end
        end
    end

    // slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_stamp[i] <= '0;
            end
        end else if (w_process) begin
            r_locked <= n_locked;
            r_stamp  <= n_stamp;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_sampled    <= n_sampled;
            r_slot_valid <= n_slot_valid;
            r_slot_id    <= n_slot_id;
            r_out_stamp  <= n_out_stamp;
            r_mask       <= 4'(n_locked);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sampled     = r_sampled;
    assign o_slot_valid  = r_slot_valid;
    assign o_slot_id     = r_slot_id;
    assign o_stamp       = r_out_stamp;
    assign o_locked_mask = r_mask;

    a_mask_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_locked_mask == 4'(r_locked)))
        else $error("result mask differs from slot lock state");

    a_frame_no_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sampled) |-> (o_stamp == 64'd0))
        else $error("frame result carries a stamp");

    a_lock_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sampled && o_slot_valid) |-> o_locked_mask[o_slot_id])
        else $error("locked slot not shown in mask");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_clock) && $stable(r_sel)))
        else $error("pending item lost during result stall");

endmodule
